/* rtl/core/bpc_pkg.sv */
package bpc_pkg;

  // Field widths
  localparam int RawW    = 24;
  localparam int CalW    = 16;
  localparam int TempW   = 19;
  localparam int PresW   = 21;
  localparam int InW     = 2 * RawW;
  localparam int OutW    = TempW + PresW;
  localparam int CfgIdxW = 3;

  // Register stages from input register to output register
  localparam int NumStages = 9;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESSURE_SENSITIVITY   = 3'd0,
    REG_PRESSURE_OFFSET        = 3'd1,
    REG_SENSITIVITY_TEMP_COEFF = 3'd2,
    REG_OFFSET_TEMP_COEFF      = 3'd3,
    REG_REFERENCE_TEMPERATURE  = 3'd4,
    REG_TEMPERATURE_COEFF      = 3'd5
  } cfg_reg_t;

  // Temperature reference points and offsets, in units of 0.01 degree
  localparam logic signed [19:0] TempRef    = 20'sd2000;
  localparam logic signed [19:0] ColdOffset = 20'sd3500;
  localparam logic signed [18:0] ColdDelta  = -19'sd3500;
  localparam logic [20:0]        KelvinOff  = 21'd27315;

  // Saturation bounds
  localparam logic signed [20:0] TempHi = 21'sd262143;
  localparam logic signed [20:0] TempLo = -21'sd262144;
  localparam logic signed [29:0] PresHi = 30'sd1048575;
  localparam logic signed [29:0] PresLo = -30'sd1048576;

  typedef struct packed {
    logic [CalW-1:0] pressure_sensitivity;
    logic [CalW-1:0] pressure_offset;
    logic [CalW-1:0] sensitivity_temp_coeff;
    logic [CalW-1:0] offset_temp_coeff;
    logic [CalW-1:0] reference_temperature;
    logic [CalW-1:0] temperature_coeff;
  } cal_t;

  // First-order results handed to the correction stages
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [18:0] a;      // TEMP - 2000
    logic signed [19:0] b;      // TEMP + 1500
    logic signed [19:0] temp;
    logic [17:0]        t2;
    logic signed [39:0] off;
    logic signed [39:0] sens;
    logic               low;
    logic               very_low;
  } first_t;

  // Corrected offset and sensitivity handed to the pressure stages
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic [TempW-1:0]   temp_out;
    logic signed [39:0] offc;
    logic signed [39:0] sensc;
  } second_t;

endpackage

/* rtl/core/bpc_ctrl.sv */
module bpc_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bpc_pkg::NumStages-1:0]  en
);
  import bpc_pkg::*;

  logic [NumStages-1:0] v;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NumStages-1] = !v[NumStages-1] || m_tready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NumStages-1];

endmodule

/* rtl/core/bpc_first.sv */
module bpc_first (
  input  logic                       clk,
  input  logic [2:0]                 en,
  input  bpc_pkg::cal_t              cal,
  input  logic [bpc_pkg::RawW-1:0]   raw_pressure,
  input  logic [bpc_pkg::RawW-1:0]   raw_temperature,
  output bpc_pkg::first_t            res
);
  import bpc_pkg::*;

  logic signed [24:0] dt;
  logic [RawW-1:0]    d1_s1;
  logic [RawW-1:0]    d1_s2;
  logic signed [41:0] p_t;
  logic signed [41:0] p_off;
  logic signed [41:0] p_sens;
  logic signed [49:0] p_dd;
  logic signed [18:0] sh_t;
  logic signed [34:0] off_sh;
  logic signed [33:0] sens_sh;

  // dT = D2 - C5 * 256
  always_ff @(posedge clk) begin
    if (en[0]) begin
      dt    <= $signed({1'b0, raw_temperature}) -
               $signed({1'b0, cal.reference_temperature, 8'h00});
      d1_s1 <= raw_pressure;
    end
  end

  // Four products of dT in parallel
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p_t    <= dt * $signed({1'b0, cal.temperature_coeff});
      p_off  <= dt * $signed({1'b0, cal.offset_temp_coeff});
      p_sens <= dt * $signed({1'b0, cal.sensitivity_temp_coeff});
      p_dd   <= dt * dt;
      d1_s2  <= d1_s1;
    end
  end

  // Floor shifts are plain part-selects of the signed products
  assign sh_t    = p_t[41:23];
  assign off_sh  = p_off[41:7];
  assign sens_sh = p_sens[41:8];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.d1       <= d1_s2;
      res.a        <= sh_t;
      res.b        <= {sh_t[18], sh_t} + ColdOffset;
      res.temp     <= {sh_t[18], sh_t} + TempRef;
      res.t2       <= p_dd[48:31];
      res.off      <= {8'h00, cal.pressure_offset, 16'h0000} +
                      {{5{off_sh[34]}}, off_sh};
      res.sens     <= {9'h000, cal.pressure_sensitivity, 15'h0000} +
                      {{6{sens_sh[33]}}, sens_sh};
      res.low      <= sh_t[18];
      res.very_low <= sh_t < ColdDelta;
    end
  end

endmodule

/* rtl/core/bpc_second.sv */
module bpc_second (
  input  logic             clk,
  input  logic [2:0]       en,
  input  bpc_pkg::first_t  fin,
  output bpc_pkg::second_t res
);
  import bpc_pkg::*;

  logic signed [37:0] a_sq;
  logic signed [39:0] b_sq;
  logic [35:0]        sq;
  logic [35:0]        sq2;
  logic signed [20:0] t_sum;
  logic signed [39:0] off_s4, sens_s4, off_s5, sens_s5;
  logic [RawW-1:0]    d1_s4, d1_s5;
  logic               low_s4, very_low_s4;
  logic [39:0]        sq5, sq7, sq11;
  logic [39:0]        off2, sens2;
  logic [TempW-1:0]   temp_s5;

  assign a_sq = fin.a * fin.a;
  assign b_sq = fin.b * fin.b;

  // Squares, and the temperature sum with T2 applied when cold
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sq          <= a_sq[35:0];
      sq2         <= b_sq[35:0];
      t_sum       <= {fin.temp[19], fin.temp} -
                     (fin.low ? {3'b000, fin.t2} : 21'd0) + KelvinOff;
      off_s4      <= fin.off;
      sens_s4     <= fin.sens;
      d1_s4       <= fin.d1;
      low_s4      <= fin.low;
      very_low_s4 <= fin.very_low;
    end
  end

  // Constant multiples by shift and add
  always_comb begin
    sq5  = ({4'h0, sq} << 2) + {4'h0, sq};
    sq7  = ({4'h0, sq2} << 3) - {4'h0, sq2};
    sq11 = ({4'h0, sq2} << 3) + ({4'h0, sq2} << 1) + {4'h0, sq2};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      off2    <= low_s4 ? (sq5 >> 1) + (very_low_s4 ? sq7 : 40'd0) : 40'd0;
      sens2   <= low_s4 ? (sq5 >> 2) + (very_low_s4 ? (sq11 >> 1) : 40'd0) : 40'd0;
      off_s5  <= off_s4;
      sens_s5 <= sens_s4;
      d1_s5   <= d1_s4;
      if (t_sum > TempHi) begin
        temp_s5 <= TempHi[TempW-1:0];
      end else if (t_sum < TempLo) begin
        temp_s5 <= TempLo[TempW-1:0];
      end else begin
        temp_s5 <= t_sum[TempW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      res.offc     <= off_s5 - $signed(off2);
      res.sensc    <= sens_s5 - $signed(sens2);
      res.d1       <= d1_s5;
      res.temp_out <= temp_s5;
    end
  end

endmodule

/* rtl/core/bpc_press.sv */
module bpc_press (
  input  logic                      clk,
  input  logic [2:0]                en,
  input  bpc_pkg::second_t          sin,
  output logic [bpc_pkg::TempW-1:0] temperature_centikelvin,
  output logic [bpc_pkg::PresW-1:0] pressure_pa
);
  import bpc_pkg::*;

  logic [43:0]        lo;
  logic signed [44:0] hi;
  logic signed [39:0] offc_s7;
  logic [TempW-1:0]   temp_s7, temp_s8;
  logic [64:0]        prod;
  logic signed [43:0] prod_sh;
  logic signed [44:0] x;
  logic signed [29:0] p;

  // D1 * sensitivity as two 24 x 20 partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      lo      <= sin.d1 * sin.sensc[19:0];
      hi      <= $signed({1'b0, sin.d1}) * $signed(sin.sensc[39:20]);
      offc_s7 <= sin.offc;
      temp_s7 <= sin.temp_out;
    end
  end

  assign prod    = {hi, 20'h00000} + {21'h000000, lo};
  assign prod_sh = prod[64:21];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      x       <= {prod_sh[43], prod_sh} - {{5{offc_s7[39]}}, offc_s7};
      temp_s8 <= temp_s7;
    end
  end

  assign p = x[44:15];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      temperature_centikelvin <= temp_s8;
      if (p > PresHi) begin
        pressure_pa <= PresHi[PresW-1:0];
      end else if (p < PresLo) begin
        pressure_pa <= PresLo[PresW-1:0];
      end else begin
        pressure_pa <= p[PresW-1:0];
      end
    end
  end

endmodule

/* rtl/core/barometric_pressure_compensation.sv */
// Second-order barometer compensation. Each transfer on the slave stream
// carries one raw pressure and one raw temperature conversion; the block
// returns compensated temperature (0.01 K) and pressure (Pa), both saturated,
// on the master stream. Items pass through a nine-stage pipeline: one item is
// taken every cycle while the output is not stalled. The stages are: dT,
// the four products of dT, the first-order sums, the squares for the cold
// correction, the correction terms, the corrected offset and sensitivity,
// the split 24 x 40 pressure product, its recombination, and the final shift
// and saturation. Each stage holds its item on backpressure and an empty stage
// keeps taking data, so bubbles close up behind a stalled output. The six
// calibration words reset to zero and are written through the config
// channel, which always accepts; write them only while no item is in flight.
module barometric_pressure_compensation (
  input  logic                          clk,
  input  logic                          rst,
  // raw_pressure [23:0], raw_temperature [47:24]
  input  logic [bpc_pkg::InW-1:0]       s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // temperature_centikelvin [18:0], pressure_pa [39:19]
  output logic [bpc_pkg::OutW-1:0]      m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bpc_pkg::CalW-1:0]      cfg_data
);
  import bpc_pkg::*;

  cal_t                 cal;
  logic [NumStages-1:0] en;
  first_t               first_res;
  second_t              second_res;
  logic [TempW-1:0]     temperature_centikelvin;
  logic [PresW-1:0]     pressure_pa;

  // Calibration words: a transfer to an index past the list is dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   <= cfg_data;
        REG_PRESSURE_OFFSET:        cal.pressure_offset        <= cfg_data;
        REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff <= cfg_data;
        REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      <= cfg_data;
        REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  <= cfg_data;
        REG_TEMPERATURE_COEFF:      cal.temperature_coeff      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Valid bits and per-stage advance enables
  bpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .en       (en)
  );

  // Stages 1-3: dT, products of dT, first-order TEMP, OFF and SENS
  bpc_first u_first (
    .clk             (clk),
    .en              (en[2:0]),
    .cal             (cal),
    .raw_pressure    (s_tdata[RawW-1:0]),
    .raw_temperature (s_tdata[InW-1:RawW]),
    .res             (first_res)
  );

  // Stages 4-6: cold corrections, output temperature, corrected OFF and SENS
  bpc_second u_second (
    .clk (clk),
    .en  (en[5:3]),
    .fin (first_res),
    .res (second_res)
  );

  // Stages 7-9: pressure product, shift, saturation, output register
  bpc_press u_press (
    .clk                     (clk),
    .en                      (en[8:6]),
    .sin                     (second_res),
    .temperature_centikelvin (temperature_centikelvin),
    .pressure_pa             (pressure_pa)
  );

  assign m_tdata = {pressure_pa, temperature_centikelvin};

endmodule

/* rtl/core/bpc_checker.sv */
module bpc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [bpc_pkg::OutW-1:0]    m_tdata,
  input logic                        m_tvalid,
  input logic                        m_tready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Input backs up only when every stage is full and the output is blocked
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input blocked with room in the pipeline");

  // With the output always taken, every transferred item emerges from the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready
      ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
      |=> m_tvalid)
    else $error("item lost in the pipeline");

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);

/* tb/compensation_checker.sv */
module compensation_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bpc_pkg::InW-1:0]     s_tdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [bpc_pkg::OutW-1:0]    m_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bpc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [bpc_pkg::CalW-1:0]    cfg_data,
  output int                          pending,
  output int                          failures
);
  import bpc_pkg::*;

  localparam longint RoomTemp    = 2000;
  localparam longint ColdLimit   = -1500;
  localparam longint ZeroCelsius = 27315;
  localparam longint TempMax     = (longint'(1) << (TempW - 1)) - 1;
  localparam longint TempMin     = -TempMax - 1;
  localparam longint PresMax     = (longint'(1) << (PresW - 1)) - 1;
  localparam longint PresMin     = -PresMax - 1;

  typedef struct {
    logic signed [TempW-1:0] temp_ck;
    logic signed [PresW-1:0] pres_pa;
  } reading_t;

  cal_t     cal;
  reading_t expected_readings[$];

  function automatic longint saturate(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  // Second-order compensation, signed 64-bit, >>> on signed operands is a floor shift
  function automatic reading_t compensate(logic [RawW-1:0] d1, logic [RawW-1:0] d2);
    longint   c1, c2, c3, c4, c5, c6;
    longint   dt, temp, off, sens, t2, off2, sens2, a, b, p;
    reading_t r;
    c1    = longint'(cal.pressure_sensitivity);
    c2    = longint'(cal.pressure_offset);
    c3    = longint'(cal.sensitivity_temp_coeff);
    c4    = longint'(cal.offset_temp_coeff);
    c5    = longint'(cal.reference_temperature);
    c6    = longint'(cal.temperature_coeff);
    dt    = longint'(d2) - c5 * 256;
    temp  = RoomTemp + ((dt * c6) >>> 23);
    off   = c2 * 65536 + ((c4 * dt) >>> 7);
    sens  = c1 * 32768 + ((c3 * dt) >>> 8);
    t2    = 0;
    off2  = 0;
    sens2 = 0;
    if (temp < RoomTemp) begin
      a     = temp - RoomTemp;
      t2    = (dt * dt) >>> 31;
      off2  = (5 * a * a) >>> 1;
      sens2 = (5 * a * a) >>> 2;
      if (temp < ColdLimit) begin
        b     = temp - ColdLimit;
        off2  = off2 + 7 * b * b;
        sens2 = sens2 + ((11 * b * b) >>> 1);
      end
    end
    off  = off - off2;
    sens = sens - sens2;
    p    = ((((longint'(d1) * sens) >>> 21) - off) >>> 15);
    r.temp_ck = TempW'(saturate(temp - t2 + ZeroCelsius, TempMin, TempMax));
    r.pres_pa = PresW'(saturate(p, PresMin, PresMax));
    return r;
  endfunction

  task automatic report(string msg);
    $display("ERROR: %s", msg);
    failures++;
  endtask

  always @(posedge clk) begin : watch
    reading_t got, want;
    if (rst) begin
      cal = '0;
      expected_readings.delete();
      pending <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.temp_ck = m_tdata[TempW-1:0];
        got.pres_pa = m_tdata[OutW-1:TempW];
        if (expected_readings.size() == 0) begin
          report($sformatf("result with none outstanding: temperature %0d, pressure %0d",
                           got.temp_ck, got.pres_pa));
        end else begin
          want = expected_readings.pop_front();
          if (got.temp_ck !== want.temp_ck)
            report($sformatf("temperature_centikelvin got %0d, expected %0d",
                             got.temp_ck, want.temp_ck));
          if (got.pres_pa !== want.pres_pa)
            report($sformatf("pressure_pa got %0d, expected %0d",
                             got.pres_pa, want.pres_pa));
        end
      end
      if (s_tvalid && s_tready)
        expected_readings.push_back(compensate(s_tdata[RawW-1:0], s_tdata[InW-1:RawW]));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PRESSURE_SENSITIVITY:   cal.pressure_sensitivity   = cfg_data;
          REG_PRESSURE_OFFSET:        cal.pressure_offset        = cfg_data;
          REG_SENSITIVITY_TEMP_COEFF: cal.sensitivity_temp_coeff = cfg_data;
          REG_OFFSET_TEMP_COEFF:      cal.offset_temp_coeff      = cfg_data;
          REG_REFERENCE_TEMPERATURE:  cal.reference_temperature  = cfg_data;
          REG_TEMPERATURE_COEFF:      cal.temperature_coeff      = cfg_data;
          default: ;  // drop writes past the register list
        endcase
      end
      pending <= expected_readings.size();
    end
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import bpc_pkg::*;

  localparam longint RoomTemp      = 2000;
  localparam longint RawMax        = (longint'(1) << RawW) - 1;
  localparam int     RandomPhases  = 5;
  localparam int     PhaseItems    = 120;
  // Indexes beyond the calibration list; writes to them must change nothing
  localparam logic [CfgIdxW-1:0] UnusedIndexLo = 3'd6;
  localparam logic [CfgIdxW-1:0] UnusedIndexHi = 3'd7;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic [InW-1:0]     s_tdata   = '0;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [OutW-1:0]    m_tdata;
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CalW-1:0]    cfg_data  = '0;
  int                 pending;
  int                 failures;

  // Sender and receiver each switch between random idling and full rate
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;
  int sent_count = 0;
  int taken_count = 0;

  // Datasheet-like calibration, the usual operating point of the sensor
  localparam cal_t TypicalCal = '{
    pressure_sensitivity:   16'd40127,
    pressure_offset:        16'd36924,
    sensitivity_temp_coeff: 16'd23317,
    offset_temp_coeff:      16'd23282,
    reference_temperature:  16'd33464,
    temperature_coeff:      16'd28312
  };
  localparam logic [RawW-1:0] TypicalPressure = 24'd9085466;
  localparam logic [RawW-1:0] TypicalTemp     = 24'd8569150;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  barometric_pressure_compensation dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  compensation_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  // Clamp a computed raw word into the 24-bit conversion range
  function automatic logic [RawW-1:0] fit_raw(longint x);
    if (x < 0) return '0;
    if (x > RawMax) return '1;
    return RawW'(x);
  endfunction

  // Pick a raw temperature whose first-order TEMP lands exactly on target:
  // the smallest dT with floor(dT*C6 / 2^23) == target - 2000
  function automatic logic [RawW-1:0] raw_temp_for(cal_t c, longint target);
    longint span, c6, dt;
    c6   = longint'(c.temperature_coeff);
    span = (target - RoomTemp) * (longint'(1) << 23);
    if (c6 == 0) return fit_raw(longint'(c.reference_temperature) * 256);
    dt = (span >= 0) ? (span + c6 - 1) / c6 : -((-span) / c6);
    return fit_raw(longint'(c.reference_temperature) * 256 + dt);
  endfunction

  // Calibration words lean on the extremes, the rest uniform
  function automatic logic [CalW-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CalW'($urandom_range(0, (1 << CalW) - 1));
    endcase
  endfunction

  // One transfer on the config channel; valid stays high for the next word
  task automatic cfg_put(logic [CfgIdxW-1:0] idx, logic [CalW-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all six words, with a write to an unused index slipped in the middle
  task automatic load_calibration(cal_t c);
    logic [CalW-1:0] words[6];
    words = '{c.pressure_sensitivity, c.pressure_offset, c.sensitivity_temp_coeff,
              c.offset_temp_coeff, c.reference_temperature, c.temperature_coeff};
    for (int i = 0; i < $size(words); i++) begin
      if (i == 3)
        cfg_put($urandom_range(0, 1) ? UnusedIndexHi : UnusedIndexLo,
                CalW'($urandom_range(0, (1 << CalW) - 1)));
      cfg_put(cfg_reg_t'(i), words[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send(logic [RawW-1:0] pressure, logic [RawW-1:0] temperature);
    int gap;
    if (sent_count % 40 == 0) steady_tx = ($urandom_range(0, 3) == 0);
    gap = steady_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {temperature, pressure};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sent_count++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Mostly well-centered samples, some near the cold thresholds, some anywhere
  task automatic send_random(cal_t c);
    logic [RawW-1:0] temperature;
    longint          centre;
    centre = longint'(c.reference_temperature) * 256;
    case ($urandom_range(0, 3))
      0: temperature = RawW'($urandom_range(0, RawMax));
      3: temperature = fit_raw(longint'(raw_temp_for(c, longint'($urandom_range(0, 6500)) - 4000))
                               + longint'($urandom_range(0, 8)) - 4);
      default: temperature = fit_raw(centre + longint'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
    send(RawW'($urandom_range(0, RawMax)), temperature);
  endtask

  // Receiver: draw a stall for every result, then take it
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (taken_count % 40 == 0) steady_rx = ($urandom_range(0, 3) == 0);
      stall = steady_rx ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken_count++;
    end
  end

  initial begin
    cal_t c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Calibration straight out of reset: all words zero
    send('1, TypicalTemp);
    send(TypicalPressure, '1);
    drain();

    // Typical calibration: field extremes and both cold thresholds, each side of them
    load_calibration(TypicalCal);
    send(TypicalPressure, TypicalTemp);
    send('0, '0);
    send('1, '1);
    send('1, '0);
    send('0, '1);
    send(TypicalPressure, raw_temp_for(TypicalCal, 2000));
    send(TypicalPressure, raw_temp_for(TypicalCal, 1999));
    send(TypicalPressure, raw_temp_for(TypicalCal, -1500));
    send(TypicalPressure, raw_temp_for(TypicalCal, -1501));
    drain();

    // Every word at full scale: drives pressure into saturation
    load_calibration('1);
    send('1, '1);
    send('1, '0);
    send('0, '0);
    send('0, '1);
    drain();

    // Every word written to zero explicitly
    load_calibration('0);
    send('1, '1);
    send('0, '0);
    drain();

    // Random phases: typical calibration first, then extreme-leaning mixes
    for (int phase = 0; phase < RandomPhases; phase++) begin
      if (phase == 0) begin
        c = TypicalCal;
      end else begin
        c = '{pick_word(), pick_word(), pick_word(),
              pick_word(), pick_word(), pick_word()};
      end
      load_calibration(c);
      for (int n = 0; n < PhaseItems; n++) begin
        // Hold off once mid-phase until the pipeline has emptied
        if (phase == 0 && n == PhaseItems / 2) drain();
        send_random(c);
      end
      drain();
    end

    // Let any stray extra result surface before the verdict
    repeat (4 * NumStages) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bpc_pkg.sv
rtl/core/bpc_ctrl.sv
rtl/core/bpc_first.sv
rtl/core/bpc_second.sv
rtl/core/bpc_press.sv
rtl/core/barometric_pressure_compensation.sv
rtl/core/bpc_checker.sv
tb/compensation_checker.sv
tb/testbench.sv
